// ===== design/cisc_pkg.sv =====
// Shared types, constants and codes of the core idle-state coordinator.
package cisc_pkg;

    // Default structural sizes
    localparam int unsigned THREADS_PER_CORE_DEF = 4;
    localparam int unsigned NUM_THREADS_DEF      = 256;

    // Request type codes
    localparam logic [1:0] REQ_SLEEP = 2'd0;
    localparam logic [1:0] REQ_WAKE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_VALID_MASK = 3'd0;
    localparam logic [2:0] CFG_LAT_D2     = 3'd1;
    localparam logic [2:0] CFG_LAT_D3     = 3'd2;
    localparam logic [2:0] CFG_LAT_D4     = 3'd3;
    localparam logic [2:0] CFG_LAT_D5     = 3'd4;
    localparam logic [2:0] CFG_LAT_D6     = 3'd5;

    // Depth values with a fixed meaning
    localparam logic [2:0] DEPTH_RUN       = 3'd0;
    localparam logic [2:0] DEPTH_SHALLOW   = 3'd1;
    localparam logic [2:0] DEPTH_FLAG_SET  = 3'd6;
    localparam logic [2:0] DEPTH_NONE      = 3'd7;

    localparam logic [6:0] VALID_MASK_RST = 7'h7F;

    // Configuration as seen by the step logic
    typedef struct packed {
        logic [6:0]       valid_depth_mask;
        logic [4:0][31:0] exit_lat;          // index 0 is depth 2
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [2:0]  prev_depth;
        logic [2:0]  core_depth;
        logic        sleep_flag;
        logic [31:0] wake_lat;
        logic        leads_wakeup;
        logic        bad_depth;
    } t_rsp;

endpackage

// ===== design/cisc_req_if.sv =====
// Request channel: valid/ready handshake carrying one request item.
interface cisc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] thread_id;
    logic [2:0] depth;

    modport source (output valid, output req_type, output thread_id, output depth,
                    input ready);
    modport sink   (input valid, input req_type, input thread_id, input depth,
                    output ready);
endinterface

// ===== design/cisc_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one result item.
interface cisc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  prev_depth;
    logic [2:0]  core_depth;
    logic        sleep_flag;
    logic [31:0] wake_lat;
    logic        leads_wakeup;
    logic        bad_depth;

    modport source (output valid, output prev_depth, output core_depth,
                    output sleep_flag, output wake_lat, output leads_wakeup,
                    output bad_depth, input ready);
    modport sink   (input valid, input prev_depth, input core_depth,
                    input sleep_flag, input wake_lat, input leads_wakeup,
                    input bad_depth, output ready);
endinterface

// ===== design/cisc_cfg.sv =====
// Configuration register bank: depth mask and per-depth exit latencies.
module cisc_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output cisc_pkg::t_cfg    o_cfg
);

    cisc_pkg::t_cfg r_cfg;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_depth_mask <= cisc_pkg::VALID_MASK_RST;
            r_cfg.exit_lat         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cisc_pkg::CFG_VALID_MASK: r_cfg.valid_depth_mask <= i_cfg_data[6:0];
                cisc_pkg::CFG_LAT_D2:     r_cfg.exit_lat[0]      <= i_cfg_data;
                cisc_pkg::CFG_LAT_D3:     r_cfg.exit_lat[1]      <= i_cfg_data;
                cisc_pkg::CFG_LAT_D4:     r_cfg.exit_lat[2]      <= i_cfg_data;
                cisc_pkg::CFG_LAT_D5:     r_cfg.exit_lat[3]      <= i_cfg_data;
                cisc_pkg::CFG_LAT_D6:     r_cfg.exit_lat[4]      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/cisc_row_mem.sv =====
// Per-core row memory (thread depths and sleep flag) with clearing pass
// after reset and write-to-read forwarding.
module cisc_row_mem #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ROW_W  = 13,
    parameter int unsigned ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ROW_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [ROW_W-1:0]  o_rdata,
    output logic              o_busy
);

    logic [ROW_W-1:0]  r_mem [DEPTH];
    logic [ROW_W-1:0]  r_rdata;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ROW_W-1:0]  wr_data;

    // Clearing pass: one row a cycle from reset until the last row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Write port shared between clearing pass and updates
    always_comb begin
        wr_en   = r_clr_busy | i_we;
        wr_addr = r_clr_busy ? r_clr_addr : i_waddr;
        wr_data = r_clr_busy ? '0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a row written at the same edge is forwarded
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

// ===== design/cisc_step.sv =====
// Step logic: one request against one core row, giving result and new row.
module cisc_step #(
    parameter int unsigned THREADS_PER_CORE = cisc_pkg::THREADS_PER_CORE_DEF,
    parameter int unsigned NUM_THREADS      = cisc_pkg::NUM_THREADS_DEF,
    parameter int unsigned CORE_W           = 6,
    parameter int unsigned LANE_W           = 2,
    parameter int unsigned ROW_W            = 3 * THREADS_PER_CORE + 1
) (
    input  logic [1:0]        i_req_type,
    input  logic              i_in_range,
    input  logic [CORE_W-1:0] i_core,
    input  logic [LANE_W-1:0] i_lane,
    input  logic [2:0]        i_depth,
    input  logic [ROW_W-1:0]  i_row,
    input  cisc_pkg::t_cfg    i_cfg,
    output cisc_pkg::t_rsp    o_rsp,
    output logic [ROW_W-1:0]  o_row,
    output logic              o_wr
);

    logic [2:0]            d_old [THREADS_PER_CORE];
    logic [2:0]            d_new [THREADS_PER_CORE];
    logic [THREADS_PER_CORE-1:0] lane_ok;
    logic [11:0]           base;
    logic [2:0]            min_old;
    logic [2:0]            min_new;
    logic [2:0]            prev;
    logic                  flag;
    logic [7:0]            mask8;
    logic                  mask_bit;

    // Unpack the row and mark lanes that map to real threads
    always_comb begin
        base = 12'(i_core) * 12'(THREADS_PER_CORE);
        for (int i = 0; i < THREADS_PER_CORE; i++) begin
            d_old[i]   = i_row[3*i +: 3];
            lane_ok[i] = (base + 12'(i)) < 12'(NUM_THREADS);
        end
        prev     = d_old[i_lane];
        mask8    = {1'b0, i_cfg.valid_depth_mask};
        mask_bit = mask8[i_depth];
    end

    // New depths for this request
    always_comb begin
        for (int i = 0; i < THREADS_PER_CORE; i++) begin
            d_new[i] = d_old[i];
        end
        if (i_req_type == cisc_pkg::REQ_SLEEP) begin
            if (i_depth > cisc_pkg::DEPTH_SHALLOW && mask_bit) begin
                d_new[i_lane] = i_depth;
            end
        end else if (i_req_type == cisc_pkg::REQ_WAKE) begin
            d_new[i_lane] = cisc_pkg::DEPTH_RUN;
        end
    end

    // Core minimum before and after the update
    always_comb begin
        min_old = cisc_pkg::DEPTH_NONE;
        min_new = cisc_pkg::DEPTH_NONE;
        for (int i = 0; i < THREADS_PER_CORE; i++) begin
            if (lane_ok[i] && d_old[i] < min_old) begin
                min_old = d_old[i];
            end
            if (lane_ok[i] && d_new[i] < min_new) begin
                min_new = d_new[i];
            end
        end
    end

    // Result fields and sleep flag
    always_comb begin
        o_rsp = '0;
        flag  = i_row[ROW_W-1];
        if (i_in_range) begin
            case (i_req_type)
                cisc_pkg::REQ_SLEEP: begin
                    if (i_depth > cisc_pkg::DEPTH_SHALLOW) begin
                        if (!mask_bit) begin
                            o_rsp.bad_depth = 1'b1;
                        end else if (min_new > cisc_pkg::DEPTH_RUN) begin
                            flag = 1'b1;
                        end
                    end
                end
                cisc_pkg::REQ_WAKE: begin
                    if (prev > cisc_pkg::DEPTH_SHALLOW && min_old > cisc_pkg::DEPTH_SHALLOW) begin
                        o_rsp.leads_wakeup = 1'b1;
                        flag               = 1'b0;
                        case (min_old)
                            3'd2:    o_rsp.wake_lat = i_cfg.exit_lat[0];
                            3'd3:    o_rsp.wake_lat = i_cfg.exit_lat[1];
                            3'd4:    o_rsp.wake_lat = i_cfg.exit_lat[2];
                            3'd5:    o_rsp.wake_lat = i_cfg.exit_lat[3];
                            3'd6:    o_rsp.wake_lat = i_cfg.exit_lat[4];
                            default: o_rsp.wake_lat = '0;
                        endcase
                    end
                end
                cisc_pkg::REQ_QUERY: begin
                    o_rsp.core_depth = flag ? cisc_pkg::DEPTH_FLAG_SET : min_old;
                end
                default: ;
            endcase
            o_rsp.prev_depth = prev;
            o_rsp.sleep_flag = flag;
        end
    end

    // Repack the row for write-back
    always_comb begin
        o_row[ROW_W-1] = flag;
        for (int i = 0; i < THREADS_PER_CORE; i++) begin
            o_row[3*i +: 3] = d_new[i];
        end
        o_wr = i_in_range && (i_req_type == cisc_pkg::REQ_SLEEP ||
                              i_req_type == cisc_pkg::REQ_WAKE);
    end

endmodule

// ===== design/core_idle_state_coordinator_core.sv =====
// Top level of the core idle-state coordinator.
//
// Requests (sleep, wakeup, query) arrive on i_req and each gives exactly one
// result item on o_rsp; both are valid/ready channels. Registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only
// while the block is idle, which the block does not enforce. Threads are
// grouped by THREADS_PER_CORE; each core keeps one memory row holding the
// depths of its threads and its sleep flag. An item is registered in the
// row-read stage, then its result in the result register. Throughput: one item
// per cycle while o_rsp is not stalled, set by the read-modify-write of one
// core row; a row written at an edge is forwarded to an item reading it at
// that same edge. Reset: after i_rst_n is released the row memory is cleared
// one row a cycle, all NUM_CORES rows (64 at the defaults); i_req.ready stays
// low during that pass while configuration writes are taken as usual. Stall:
// when o_rsp is held the result register keeps its item, the item in the
// row-read stage waits behind it, and i_req.ready drops once both are full.
module core_idle_state_coordinator_core #(
    parameter int unsigned THREADS_PER_CORE = cisc_pkg::THREADS_PER_CORE_DEF,
    parameter int unsigned NUM_THREADS      = cisc_pkg::NUM_THREADS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cisc_req_if.sink    i_req,
    cisc_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned NUM_CORES = (NUM_THREADS + THREADS_PER_CORE - 1) / THREADS_PER_CORE;
    localparam int unsigned CORE_W    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int unsigned LANE_W    = (THREADS_PER_CORE > 1) ? $clog2(THREADS_PER_CORE) : 1;
    localparam int unsigned ROW_W     = 3 * THREADS_PER_CORE + 1;
    localparam int unsigned RECIP_SH  = 16;
    localparam int unsigned RECIP     = ((1 << RECIP_SH) + THREADS_PER_CORE - 1) / THREADS_PER_CORE;

    cisc_pkg::t_cfg     cfg;
    cisc_pkg::t_rsp     step_rsp;
    logic [ROW_W-1:0]   step_row;
    logic               step_wr;
    logic [ROW_W-1:0]   mem_rdata;
    logic               mem_busy;

    logic [24:0]        div_prod;
    logic [7:0]         in_core8;
    logic [10:0]        in_base;
    logic [7:0]         in_lane8;
    logic [CORE_W+7:0]  in_core_ext;
    logic [CORE_W-1:0]  in_core;
    logic               in_range;
    logic               in_ready;
    logic               in_acc;
    logic               a_adv;

    // Row-read stage registers
    logic               r_a_v;
    logic [1:0]         r_a_req;
    logic               r_a_range;
    logic [CORE_W-1:0]  r_a_core;
    logic [LANE_W-1:0]  r_a_lane;
    logic [2:0]         r_a_dep;

    // Result register
    logic               r_o_v;
    cisc_pkg::t_rsp     r_o_rsp;

    cisc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Core and lane of the incoming thread: divide by reciprocal multiply
    always_comb begin
        div_prod    = 25'(i_req.thread_id) * 25'(RECIP);
        in_core8    = div_prod[RECIP_SH +: 8];
        in_base     = 11'(in_core8) * 11'(THREADS_PER_CORE);
        in_lane8    = i_req.thread_id - in_base[7:0];
        in_core_ext = {{CORE_W{1'b0}}, in_core8};
        in_range    = {3'b000, i_req.thread_id} < 11'(NUM_THREADS);
        in_core     = in_range ? in_core_ext[CORE_W-1:0] : '0;
    end

    // Handshake control
    assign a_adv       = r_a_v && (!r_o_v || o_rsp.ready);
    assign in_ready    = !mem_busy && (!r_a_v || a_adv);
    assign in_acc      = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    cisc_row_mem #(
        .DEPTH  (NUM_CORES),
        .ROW_W  (ROW_W),
        .ADDR_W (CORE_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (a_adv && step_wr),
        .i_waddr (r_a_core),
        .i_wdata (step_row),
        .i_re    (in_acc),
        .i_raddr (in_core),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    // Row-read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (in_ready) begin
            r_a_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_req   <= i_req.req_type;
            r_a_range <= in_range;
            r_a_core  <= in_core;
            r_a_lane  <= in_lane8[LANE_W-1:0];
            r_a_dep   <= i_req.depth;
        end
    end

    cisc_step #(
        .THREADS_PER_CORE (THREADS_PER_CORE),
        .NUM_THREADS      (NUM_THREADS),
        .CORE_W           (CORE_W),
        .LANE_W           (LANE_W),
        .ROW_W            (ROW_W)
    ) u_step (
        .i_req_type (r_a_req),
        .i_in_range (r_a_range),
        .i_core     (r_a_core),
        .i_lane     (r_a_lane),
        .i_depth    (r_a_dep),
        .i_row      (mem_rdata),
        .i_cfg      (cfg),
        .o_rsp      (step_rsp),
        .o_row      (step_row),
        .o_wr       (step_wr)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (a_adv) begin
            r_o_v <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o_rsp <= step_rsp;
        end
    end

    assign o_rsp.valid        = r_o_v;
    assign o_rsp.prev_depth   = r_o_rsp.prev_depth;
    assign o_rsp.core_depth   = r_o_rsp.core_depth;
    assign o_rsp.sleep_flag   = r_o_rsp.sleep_flag;
    assign o_rsp.wake_lat     = r_o_rsp.wake_lat;
    assign o_rsp.leads_wakeup = r_o_rsp.leads_wakeup;
    assign o_rsp.bad_depth    = r_o_rsp.bad_depth;

endmodule

// ===== design/cisc_chk.sv =====
// Port-level checker for the coordinator, bound to the top level.
module cisc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [2:0]  i_prev_depth,
    input logic [2:0]  i_core_depth,
    input logic        i_sleep_flag,
    input logic [31:0] i_wake_lat,
    input logic        i_leads_wakeup,
    input logic        i_bad_depth
);

    // A held result item stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result item withdrawn while stalled");

    // A held result item keeps its payload
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_prev_depth) && $stable(i_core_depth) && $stable(i_sleep_flag) &&
            $stable(i_wake_lat) && $stable(i_leads_wakeup) && $stable(i_bad_depth))
        else $error("result payload changed while stalled");

    // A leading wakeup always leaves the core flag clear
    a_lead_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_leads_wakeup |-> !i_sleep_flag && i_core_depth == 3'd0)
        else $error("leading wakeup left the sleep flag set");

    // A rejected sleep depth reports no wakeup and no query answer
    a_bad_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_bad_depth |->
            !i_leads_wakeup && i_wake_lat == 32'd0 && i_core_depth == 3'd0)
        else $error("bad depth item carries wakeup or query fields");

    // Latency is only reported by a leading wakeup
    a_lat_needs_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_wake_lat != 32'd0 |-> i_leads_wakeup)
        else $error("exit latency without a leading wakeup");

endmodule

bind core_idle_state_coordinator_core cisc_chk u_cisc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_prev_depth   (o_rsp.prev_depth),
    .i_core_depth   (o_rsp.core_depth),
    .i_sleep_flag   (o_rsp.sleep_flag),
    .i_wake_lat     (o_rsp.wake_lat),
    .i_leads_wakeup (o_rsp.leads_wakeup),
    .i_bad_depth    (o_rsp.bad_depth)
);

// ===== verif/core_idle_state_coordinator_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the core idle-state coordinator: predictor scoreboard and drivers.
module core_idle_state_coordinator_core_test;

    localparam int unsigned NTHR        = cisc_pkg::NUM_THREADS_DEF;
    localparam int unsigned TPC         = cisc_pkg::THREADS_PER_CORE_DEF;
    localparam int unsigned NCORE       = (NTHR + TPC - 1) / TPC;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned DRAIN       = 6;

    // Predicts the result of every accepted request and checks the results in order
    class idle_state_scoreboard;
        logic [2:0]     depth_of [NTHR];
        bit             asleep_flag [NCORE];
        logic [6:0]     depth_mask;
        logic [31:0]    wake_cost [5];
        cisc_pkg::t_rsp pending_results [$];
        int             fails;

        function new();
            foreach (depth_of[i]) depth_of[i] = cisc_pkg::DEPTH_RUN;
            foreach (asleep_flag[i]) asleep_flag[i] = 1'b0;
            foreach (wake_cost[i]) wake_cost[i] = '0;
            depth_mask = cisc_pkg::VALID_MASK_RST;
            fails      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                cisc_pkg::CFG_VALID_MASK: depth_mask = data[6:0];
                cisc_pkg::CFG_LAT_D2, cisc_pkg::CFG_LAT_D3, cisc_pkg::CFG_LAT_D4,
                cisc_pkg::CFG_LAT_D5, cisc_pkg::CFG_LAT_D6:
                    wake_cost[idx - cisc_pkg::CFG_LAT_D2] = data;
                default: ;
            endcase
        endfunction

        // Shallowest depth among the threads of one core
        function logic [2:0] core_min(int unsigned core);
            logic [2:0]  m;
            int unsigned t;
            m = cisc_pkg::DEPTH_NONE;
            for (int unsigned i = 0; i < TPC; i++) begin
                t = core * TPC + i;
                if (t < NTHR && depth_of[t] < m) m = depth_of[t];
            end
            return m;
        endfunction

        function void note_request(logic [1:0] kind, logic [7:0] tid, logic [2:0] dep);
            cisc_pkg::t_rsp e;
            int unsigned    core;
            logic [2:0]     m;
            bit [7:0]       known;
            e = '0;
            if (tid >= NTHR) begin
                pending_results.push_back(e);
                return;
            end
            core         = tid / TPC;
            e.prev_depth = depth_of[tid];
            known        = {1'b0, depth_mask};
            case (kind)
                cisc_pkg::REQ_SLEEP: begin
                    // depths 0 and 1 change nothing; unknown depths are refused
                    if (dep > cisc_pkg::DEPTH_SHALLOW) begin
                        if (!known[dep]) begin
                            e.bad_depth = 1'b1;
                        end else begin
                            depth_of[tid] = dep;
                            if (core_min(core) != cisc_pkg::DEPTH_RUN)
                                asleep_flag[core] = 1'b1;
                        end
                    end
                end
                cisc_pkg::REQ_WAKE: begin
                    // minimum is taken before the thread returns to running
                    m = core_min(core);
                    depth_of[tid] = cisc_pkg::DEPTH_RUN;
                    if (e.prev_depth > cisc_pkg::DEPTH_SHALLOW &&
                        m > cisc_pkg::DEPTH_SHALLOW) begin
                        e.leads_wakeup = 1'b1;
                        if (m <= cisc_pkg::DEPTH_FLAG_SET) e.wake_lat = wake_cost[m - 3'd2];
                        asleep_flag[core] = 1'b0;
                    end
                end
                cisc_pkg::REQ_QUERY:
                    e.core_depth = asleep_flag[core] ? cisc_pkg::DEPTH_FLAG_SET
                                                     : core_min(core);
                default: ;
            endcase
            e.sleep_flag = asleep_flag[core];
            pending_results.push_back(e);
        endfunction

        function void check_result(cisc_pkg::t_rsp got);
            cisc_pkg::t_rsp e;
            if (pending_results.size() == 0) begin
                if (fails < 10) $display("%0t: result item with nothing expected", $realtime);
                fails++;
                return;
            end
            e = pending_results.pop_front();
            if (got !== e) begin
                // fields in order: prev, core, flag, latency, lead, bad
                if (fails < 10)
                    $display("%0t: mismatch exp %0d %0d %b %h %b %b got %0d %0d %b %h %b %b",
                             $realtime, e.prev_depth, e.core_depth, e.sleep_flag,
                             e.wake_lat, e.leads_wakeup, e.bad_depth,
                             got.prev_depth, got.core_depth, got.sleep_flag,
                             got.wake_lat, got.leads_wakeup, got.bad_depth);
                fails++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    cisc_req_if req_if ();
    cisc_rsp_if rsp_if ();

    idle_state_scoreboard sb = new();
    int          req_idle_pct = 30;
    int          rsp_idle_pct = 30;
    int unsigned quiet_cycles = 0;

    core_idle_state_coordinator_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result-side back-pressure in random bursts
    initial begin
        int  burst;
        bit  hold;
        rsp_if.ready = 1'b0;
        forever begin
            burst = $urandom_range(1, 12);
            hold  = ($urandom_range(0, 99) < rsp_idle_pct);
            repeat (burst) begin
                @(negedge clk);
                rsp_if.ready <= !hold;
            end
        end
    end

    // Sample both channels at the rising edge
    always @(posedge clk) begin
        cisc_pkg::t_rsp got;
        bit             moved;
        moved = 1'b0;
        if (rst_n === 1'b1 && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            sb.note_request(req_if.req_type, req_if.thread_id, req_if.depth);
            moved = 1'b1;
        end
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.prev_depth   = rsp_if.prev_depth;
            got.core_depth   = rsp_if.core_depth;
            got.sleep_flag   = rsp_if.sleep_flag;
            got.wake_lat     = rsp_if.wake_lat;
            got.leads_wakeup = rsp_if.leads_wakeup;
            got.bad_depth    = rsp_if.bad_depth;
            sb.check_result(got);
            moved = 1'b1;
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    // Ends a run in which nothing moves for too long
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge clk);
        $display("FAIL core_idle_state_coordinator_core");
        $finish;
    end

    task automatic pause_requests(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
    endtask

    // One request item, after an occasional random gap
    task automatic send_request(input logic [1:0] kind, input logic [7:0] tid,
                                input logic [2:0] dep);
        if ($urandom_range(0, 99) < req_idle_pct) pause_requests($urandom_range(1, 12));
        @(negedge clk);
        req_if.valid     <= 1'b1;
        req_if.req_type  <= kind;
        req_if.thread_id <= tid;
        req_if.depth     <= dep;
        do @(posedge clk); while (req_if.ready !== 1'b1);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(input logic [31:0] mask_word, input logic [31:0] l2,
                                input logic [31:0] l3, input logic [31:0] l4,
                                input logic [31:0] l5, input logic [31:0] l6);
        write_reg(cisc_pkg::CFG_VALID_MASK, mask_word);
        write_reg(cisc_pkg::CFG_LAT_D2, l2);
        write_reg(cisc_pkg::CFG_LAT_D3, l3);
        write_reg(cisc_pkg::CFG_LAT_D4, l4);
        write_reg(cisc_pkg::CFG_LAT_D5, l5);
        write_reg(cisc_pkg::CFG_LAT_D6, l6);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline drain
    task automatic settle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Mostly well-formed traffic on a few busy cores, with some noise
    task automatic random_items(input int count);
        int unsigned hot [3];
        int          roll;
        logic [1:0]  kind;
        logic [7:0]  tid;
        logic [2:0]  dep;
        hot[0] = $urandom_range(0, 1) ? 0 : NCORE - 1;
        hot[1] = $urandom_range(0, NCORE - 1);
        hot[2] = $urandom_range(0, NCORE - 1);
        repeat (count) begin
            if ($urandom_range(0, 99) < 85)
                tid = 8'(hot[$urandom_range(0, 2)] * TPC + $urandom_range(0, TPC - 1));
            else
                tid = 8'($urandom_range(0, 255));
            dep  = 3'($urandom_range(0, 7));
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                kind = cisc_pkg::REQ_SLEEP;
                dep  = 3'($urandom_range(2, 6));
            end else if (roll < 55) begin
                kind = cisc_pkg::REQ_SLEEP;
            end else if (roll < 85) begin
                kind = cisc_pkg::REQ_WAKE;
            end else if (roll < 95) begin
                kind = cisc_pkg::REQ_QUERY;
            end else begin
                kind = 2'($urandom_range(0, 3));
            end
            send_request(kind, tid, dep);
        end
    endtask

    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = cisc_pkg::CFG_VALID_MASK;
        cfg_data         = '0;
        req_if.valid     = 1'b0;
        req_if.req_type  = cisc_pkg::REQ_SLEEP;
        req_if.thread_id = '0;
        req_if.depth     = cisc_pkg::DEPTH_RUN;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: query, refused depth, shallow sleeps, unknown type, idle wakeup
        send_request(cisc_pkg::REQ_QUERY, 8'd0, cisc_pkg::DEPTH_RUN);
        send_request(cisc_pkg::REQ_SLEEP, 8'd0, cisc_pkg::DEPTH_NONE);
        send_request(cisc_pkg::REQ_SLEEP, 8'd0, cisc_pkg::DEPTH_SHALLOW);
        send_request(cisc_pkg::REQ_SLEEP, 8'd1, cisc_pkg::DEPTH_RUN);
        send_request(2'd3, 8'd255, 3'd5);
        send_request(cisc_pkg::REQ_WAKE, 8'd0, cisc_pkg::DEPTH_RUN);
        settle();
        program_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0000_1234,
                     32'h8000_0001, 32'h7FFF_FFFF);

        // Last core fills up, sets its flag, then a leading and a trailing wakeup
        send_request(cisc_pkg::REQ_SLEEP, 8'd252, 3'd6);
        send_request(cisc_pkg::REQ_SLEEP, 8'd253, 3'd5);
        send_request(cisc_pkg::REQ_SLEEP, 8'd254, 3'd4);
        send_request(cisc_pkg::REQ_SLEEP, 8'd255, 3'd3);
        send_request(cisc_pkg::REQ_QUERY, 8'd253, cisc_pkg::DEPTH_RUN);
        send_request(cisc_pkg::REQ_WAKE, 8'd254, cisc_pkg::DEPTH_RUN);
        send_request(cisc_pkg::REQ_WAKE, 8'd255, cisc_pkg::DEPTH_RUN);
        send_request(cisc_pkg::REQ_QUERY, 8'd252, cisc_pkg::DEPTH_RUN);

        // Core 1 asleep at depth 5, then depth 5 removed from the mask
        send_request(cisc_pkg::REQ_SLEEP, 8'd4, 3'd5);
        send_request(cisc_pkg::REQ_SLEEP, 8'd5, 3'd5);
        send_request(cisc_pkg::REQ_SLEEP, 8'd6, 3'd5);
        send_request(cisc_pkg::REQ_SLEEP, 8'd7, 3'd5);
        settle();
        write_reg(cisc_pkg::CFG_VALID_MASK, 32'h0000_005F);
        send_request(cisc_pkg::REQ_SLEEP, 8'd8, 3'd5);
        send_request(cisc_pkg::REQ_WAKE, 8'd5, cisc_pkg::DEPTH_RUN);

        // Random phases under several register settings
        random_items(80);
        settle();
        program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_items(80);
        settle();
        program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        random_items(20);
        settle();
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        program_regs(32'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_items(60);
        settle();
        req_idle_pct = 30;
        rsp_idle_pct = 30;
        program_regs($urandom | 32'h7C, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_items(80);

        // Final stretch without any idling
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        random_items(60);
        settle();

        if (sb.fails == 0 && sb.pending_results.size() == 0) begin
            $display("PASS core_idle_state_coordinator_core");
        end else begin
            $display("FAIL core_idle_state_coordinator_core");
        end
        $finish;
    end

endmodule
